### design/smtn_pkg.sv
// Shared types and constants of the sorted mass table.
package smtn_pkg;

    // Fixed field widths of the item and result ports.
    localparam int MASS_W   = 32;
    localparam int IN_ID_W  = 16;
    localparam int OUT_ID_W = 16;
    localparam int STATUS_W = 3;

    // Action codes of an input item.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

endpackage

### design/smtn_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module smtn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/sorted_mass_table_nearest.sv
// Sorted mass table with insert and nearest-mass query.
//
// An item is accepted at a rising edge with i_start high and o_busy low.
// i_action selects insert (store i_mass with i_entry_id in sorted order,
// or replace the id of an equal mass) or query (return the stored entry
// nearest i_mass, the lower mass winning a tie). Exactly one result per
// item appears on o_status, o_found_id and o_found_mass for one cycle,
// marked by o_valid; the receiver cannot hold it off.
//
// With n entries stored, a search takes at most s = ceil(log2(n+1)) steps.
// A query on an empty table gives its result in the cycle after acceptance.
// Any other query reads one neighbor, or both, once the search ends.
// An insert that replaces, finds the table full or appends last needs no
// shift; otherwise the n - pos heavier entries first shift up one place.
// Each search step reads the RAM through its registered port and then
// compares the entry read; the shift moves one entry per cycle over the
// RAM's read and write ports.
// o_busy is high from acceptance until the result cycle (not for an empty query).
// Synchronous reset empties the table; RAM contents are not cleared, as
// only entries below the fill count are ever read.
module sorted_mass_table_nearest import smtn_pkg::*; #(
    parameter int TABLE_DEPTH = 256,
    parameter int ID_BITS     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_action,
    input  logic [MASS_W-1:0]   i_mass,
    input  logic [IN_ID_W-1:0]  i_entry_id,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [OUT_ID_W-1:0] o_found_id,
    output logic [MASS_W-1:0]   o_found_mass
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = MASS_W + ID_BITS;
    localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SRCH_CMP,
        S_CHK,
        S_SHIFT,
        S_INS_WR,
        S_Q_ONE,
        S_Q_LO,
        S_Q_HI
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [CW-1:0]       r_mid, n_mid;
    logic                r_action, n_action;
    logic [MASS_W-1:0]   r_key, n_key;
    logic [ID_BITS-1:0]  r_id, n_id;
    logic [AW-1:0]       r_src, n_src;
    logic [CW-1:0]       r_left, n_left;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_wr_addr, n_wr_addr;
    logic [MASS_W-1:0]   r_lo_mass, n_lo_mass;
    logic [ID_BITS-1:0]  r_lo_id, n_lo_id;
    logic                r_valid, n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [OUT_ID_W-1:0] r_fid, n_fid;
    logic [MASS_W-1:0]   r_fmass, n_fmass;

    // RAM port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic [MASS_W-1:0]           rd_mass;
    logic [ID_BITS-1:0]          rd_id;
    logic [ID_BITS+IN_ID_W-1:0]  in_id_ext;
    logic [ID_BITS+OUT_ID_W-1:0] rd_id_ext;
    logic [ID_BITS+OUT_ID_W-1:0] lo_id_ext;
    logic [CW-1:0]               mid;
    logic [CW-1:0]               pos_m1;
    logic [CW-1:0]               cnt_m1;
    logic [MASS_W-1:0]           d_lo;
    logic [MASS_W-1:0]           d_hi;

    smtn_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Split the RAM word and fit ids between the port and stored widths.
    assign rd_mass   = ram_rdata[MASS_W-1:0];
    assign rd_id     = ram_rdata[DW-1:MASS_W];
    assign in_id_ext = {{ID_BITS{1'b0}}, i_entry_id};
    assign rd_id_ext = {{OUT_ID_W{1'b0}}, rd_id};
    assign lo_id_ext = {{OUT_ID_W{1'b0}}, r_lo_id};

    // Search arithmetic; r_lo holds the lower-bound position when the search ends.
    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign pos_m1 = r_lo - CW'(1);
    assign cnt_m1 = r_count - CW'(1);
    assign d_lo   = r_key - r_lo_mass;
    assign d_hi   = rd_mass - r_key;

    // Next-state logic and RAM control.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_action  = r_action;
        n_key     = r_key;
        n_id      = r_id;
        n_src     = r_src;
        n_left    = r_left;
        n_pend    = r_pend;
        n_wr_addr = r_wr_addr;
        n_lo_mass = r_lo_mass;
        n_lo_id   = r_lo_id;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_fid     = r_fid;
        n_fmass   = r_fmass;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_action = i_action;
                    n_key    = i_mass;
                    n_id     = in_id_ext[ID_BITS-1:0];
                    if (i_action == ACT_QUERY && r_count == '0) begin
                        n_valid  = 1'b1;
                        n_status = ST_EMPTY;
                        n_fid    = '0;
                        n_fmass  = '0;
                    end else begin
                        n_lo    = '0;
                        n_hi    = r_count;
                        n_state = S_SRCH;
                    end
                end
            end

            S_SRCH: begin
                if (r_lo < r_hi) begin
                    ram_raddr = mid[AW-1:0];
                    n_mid     = mid;
                    n_state   = S_SRCH_CMP;
                end else if (r_action == ACT_INSERT) begin
                    if (r_lo < r_count) begin
                        ram_raddr = r_lo[AW-1:0];
                        n_state   = S_CHK;
                    end else if (r_count == DepthC) begin
                        n_valid  = 1'b1;
                        n_status = ST_FULL;
                        n_fid    = '0;
                        n_fmass  = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_src   = cnt_m1[AW-1:0];
                        n_left  = r_count - r_lo;
                        n_pend  = 1'b0;
                        n_state = (r_count == r_lo) ? S_INS_WR : S_SHIFT;
                    end
                end else begin
                    if (r_lo == '0) begin
                        ram_raddr = '0;
                        n_state   = S_Q_ONE;
                    end else if (r_lo >= r_count) begin
                        ram_raddr = pos_m1[AW-1:0];
                        n_state   = S_Q_ONE;
                    end else begin
                        ram_raddr = pos_m1[AW-1:0];
                        n_state   = S_Q_LO;
                    end
                end
            end

            S_SRCH_CMP: begin
                if (rd_mass < r_key) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SRCH;
            end

            S_CHK: begin
                if (rd_mass == r_key) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_lo[AW-1:0];
                    ram_wdata = {r_id, r_key};
                    n_valid   = 1'b1;
                    n_status  = ST_REPLACED;
                    n_fid     = '0;
                    n_fmass   = '0;
                    n_state   = S_IDLE;
                end else if (r_count == DepthC) begin
                    n_valid  = 1'b1;
                    n_status = ST_FULL;
                    n_fid    = '0;
                    n_fmass  = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_src   = cnt_m1[AW-1:0];
                    n_left  = r_count - r_lo;
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end
            end

            // Move heavier entries up one place, top down: read one entry
            // while the one read before it is written above itself.
            S_SHIFT: begin
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wr_addr;
                    ram_wdata = ram_rdata;
                end
                if (r_left != '0) begin
                    ram_raddr = r_src;
                    n_pend    = 1'b1;
                    n_wr_addr = r_src + AW'(1);
                    n_src     = r_src - AW'(1);
                    n_left    = r_left - CW'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_INS_WR;
                end
            end

            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_lo[AW-1:0];
                ram_wdata = {r_id, r_key};
                n_count   = r_count + CW'(1);
                n_valid   = 1'b1;
                n_status  = ST_INSERTED;
                n_fid     = '0;
                n_fmass   = '0;
                n_state   = S_IDLE;
            end

            S_Q_ONE: begin
                n_valid  = 1'b1;
                n_status = ST_FOUND;
                n_fid    = rd_id_ext[OUT_ID_W-1:0];
                n_fmass  = rd_mass;
                n_state  = S_IDLE;
            end

            S_Q_LO: begin
                n_lo_mass = rd_mass;
                n_lo_id   = rd_id;
                ram_raddr = r_lo[AW-1:0];
                n_state   = S_Q_HI;
            end

            // Neighbors on both sides: the nearer wins, the lower on a tie.
            S_Q_HI: begin
                n_valid  = 1'b1;
                n_status = ST_FOUND;
                if (d_lo <= d_hi) begin
                    n_fid   = lo_id_ext[OUT_ID_W-1:0];
                    n_fmass = r_lo_mass;
                end else begin
                    n_fid   = rd_id_ext[OUT_ID_W-1:0];
                    n_fmass = rd_mass;
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, working registers and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_action  <= n_action;
        r_key     <= n_key;
        r_id      <= n_id;
        r_src     <= n_src;
        r_left    <= n_left;
        r_wr_addr <= n_wr_addr;
        r_lo_mass <= n_lo_mass;
        r_lo_id   <= n_lo_id;
        r_status  <= n_status;
        r_fid     <= n_fid;
        r_fmass   <= n_fmass;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_found_id   = r_fid;
    assign o_found_mass = r_fmass;

endmodule

### design/smtn_checker.sv
// Port-level checks of the sorted mass table, bound to the top level.
module smtn_checker import smtn_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input logic                i_action,
    input logic [MASS_W-1:0]   i_mass,
    input logic [IN_ID_W-1:0]  i_entry_id,
    input logic                o_valid,
    input logic [STATUS_W-1:0] o_status,
    input logic [OUT_ID_W-1:0] o_found_id,
    input logic [MASS_W-1:0]   o_found_mass
);

    // An accepted item either keeps the block busy or gives its result at once.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_valid))
        else $error("accepted item neither busy nor answered");

    // A result only shows once the block has gone idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while busy");

    // Leaving busy always delivers the item's result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_busy) && $past(i_rst_n)) |-> o_valid)
        else $error("busy dropped without a result");

    // Only a found query carries an entry.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_FOUND) |-> (o_found_id == '0 && o_found_mass == '0))
        else $error("entry fields set on a result that is not a found query");

    // A query answered at once reports an empty table.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_action == ACT_QUERY) |=>
            (o_busy || (o_valid && o_status == ST_EMPTY)))
        else $error("query answered directly without empty status");

endmodule

bind sorted_mass_table_nearest smtn_checker u_smtn_checker (.*);

### verif/sorted_mass_table_nearest_tb.sv
// Self-checking testbench for the sorted mass table with nearest-mass query.
`timescale 1ns / 100ps

module sorted_mass_table_nearest_tb import smtn_pkg::*;;

    localparam int          TABLE_DEPTH  = 256;
    localparam int          ID_BITS      = 16;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned TAIL_CYCLES  = 300;
    localparam int unsigned IDLE_PERCENT = 12;

    // One expected result of the block.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OUT_ID_W-1:0] id;
        logic [MASS_W-1:0]   mass;
    } t_table_result;

    // Sorted table mirror: predicts the result of every accepted item and
    // checks the block's results against them in order.
    class nearest_mass_table;
        logic [MASS_W-1:0]  masses [TABLE_DEPTH];
        logic [ID_BITS-1:0] ids    [TABLE_DEPTH];
        int unsigned        fill;
        int unsigned        mismatches;
        t_table_result      expected_results [$];

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        // Index of the first stored mass not below the key, or fill if none.
        function int unsigned first_not_below(logic [MASS_W-1:0] key);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = fill;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (masses[mid] < key) lo = mid + 1;
                else hi = mid;
            end
            return lo;
        endfunction

        function void note_request(logic act, logic [MASS_W-1:0] key,
                                   logic [IN_ID_W-1:0] entry_id);
            t_table_result      res;
            int unsigned        pos;
            int unsigned        pick;
            logic [MASS_W-1:0]  d_lo;
            logic [MASS_W-1:0]  d_hi;
            logic [ID_BITS-1:0] id;
            id         = entry_id[ID_BITS-1:0];
            res.status = ST_INSERTED;
            res.id     = '0;
            res.mass   = '0;
            pos        = first_not_below(key);
            if (act == ACT_INSERT) begin
                // An equal mass only swaps its id, even in a full table.
                if (pos < fill && masses[pos] == key) begin
                    ids[pos]   = id;
                    res.status = ST_REPLACED;
                end else if (fill >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int unsigned i = fill; i > pos; i--) begin
                        masses[i] = masses[i-1];
                        ids[i]    = ids[i-1];
                    end
                    masses[pos] = key;
                    ids[pos]    = id;
                    fill++;
                    res.status = ST_INSERTED;
                end
            end else if (fill == 0) begin
                res.status = ST_EMPTY;
            end else begin
                // Nearest of the two neighbors of the lower bound; a tie
                // goes to the lower mass.
                if (pos == 0) begin
                    pick = 0;
                end else if (pos >= fill) begin
                    pick = pos - 1;
                end else begin
                    d_lo = key - masses[pos-1];
                    d_hi = masses[pos] - key;
                    pick = (d_lo <= d_hi) ? pos - 1 : pos;
                end
                res.status = ST_FOUND;
                res.id     = OUT_ID_W'(ids[pick]);
                res.mass   = masses[pick];
            end
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status,
                                   logic [OUT_ID_W-1:0] id, logic [MASS_W-1:0] mass);
            t_table_result res;
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d found_id 0x%h found_mass 0x%h",
                       status, id, mass);
                mismatches++;
                return;
            end
            res = expected_results.pop_front();
            if (status !== res.status) begin
                $error("status: expected %0d, actual %0d", res.status, status);
                mismatches++;
            end
            if (id !== res.id) begin
                $error("found_id: expected 0x%h, actual 0x%h", res.id, id);
                mismatches++;
            end
            if (mass !== res.mass) begin
                $error("found_mass: expected 0x%h, actual 0x%h", res.mass, mass);
                mismatches++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic                i_action;
    logic [MASS_W-1:0]   i_mass;
    logic [IN_ID_W-1:0]  i_entry_id;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [OUT_ID_W-1:0] o_found_id;
    logic [MASS_W-1:0]   o_found_mass;

    nearest_mass_table  table_model;
    logic [MASS_W-1:0]  used_masses [$];
    bit                 idle_en;
    int unsigned        quiet_cycles;

    sorted_mass_table_nearest #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_action     (i_action),
        .i_mass       (i_mass),
        .i_entry_id   (i_entry_id),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_found_id   (o_found_id),
        .o_found_mass (o_found_mass)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check every result strobe and watch for a hung block.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) table_model.check_result(o_status, o_found_id, o_found_mass);
            if (o_valid || (i_start && !o_busy)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // Present one item, with an optional random gap first, and hold it
    // until the block takes it.
    task automatic send_item(input logic act, input logic [MASS_W-1:0] mass,
                             input logic [IN_ID_W-1:0] entry_id);
        while (idle_en && $urandom_range(99) < IDLE_PERCENT) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_action   <= act;
        i_mass     <= mass;
        i_entry_id <= entry_id;
        do @(posedge i_clk); while (o_busy);
        table_model.note_request(act, mass, entry_id);
        if (act == ACT_INSERT) used_masses.push_back(mass);
    endtask

    // Stop sending until every expected result has come back.
    task automatic drain_results();
        i_start <= 1'b0;
        while (table_model.expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Mass biased toward stored masses, their neighbors, midpoints between
    // them and a coarse grid, so replaces and nearest-tie cases are common.
    function automatic logic [MASS_W-1:0] pick_mass();
        int unsigned       sel;
        logic [MASS_W-1:0] a;
        logic [MASS_W-1:0] b;
        logic [MASS_W:0]   sum;
        sel = $urandom_range(99);
        if (sel < 3) return '0;
        if (sel < 6) return '1;
        if (sel < 14) return MASS_W'($urandom_range(63)) << 16;
        if (sel < 20) return (MASS_W'($urandom_range(62)) << 16) + 32'h0000_8000;
        if (used_masses.size() == 0 || sel < 40) return $urandom;
        a = used_masses[$urandom_range(used_masses.size() - 1)];
        b = used_masses[$urandom_range(used_masses.size() - 1)];
        if (sel < 62) return a;
        if (sel < 78) return $urandom_range(1) ? a + $urandom_range(1, 3) : a - $urandom_range(1, 3);
        sum = {1'b0, a} + {1'b0, b};
        return sum[MASS_W:1];
    endfunction

    task automatic send_random(input int unsigned n, input int unsigned calm_from,
                               input int unsigned calm_to);
        logic act;
        for (int unsigned k = 0; k < n; k++) begin
            idle_en = !(k >= calm_from && k < calm_to);
            act     = ($urandom_range(99) < 45) ? ACT_QUERY : ACT_INSERT;
            send_item(act, pick_mass(), IN_ID_W'($urandom));
        end
        idle_en = 1'b1;
    endtask

    initial begin
        table_model  = new();
        idle_en      = 1'b1;
        quiet_cycles = 0;
        i_rst_n    <= 1'b0;
        i_start    <= 1'b0;
        i_action   <= ACT_INSERT;
        i_mass     <= '0;
        i_entry_id <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extreme masses and ids, replaces, ties.
        send_item(ACT_QUERY,  32'h0000_0000, 16'h1234);
        send_item(ACT_QUERY,  32'hFFFF_FFFF, 16'hFFFF);
        send_item(ACT_INSERT, 32'h0001_8000, 16'hFFFF);
        send_item(ACT_INSERT, 32'h0000_0000, 16'h0000);
        send_item(ACT_INSERT, 32'hFFFF_FFFF, 16'h8001);
        send_item(ACT_QUERY,  32'h0000_0000, 16'h0000);
        send_item(ACT_QUERY,  32'hFFFF_FFFF, 16'h0000);
        send_item(ACT_QUERY,  32'h0000_C000, 16'h0000);
        send_item(ACT_QUERY,  32'h0000_C001, 16'h0000);
        send_item(ACT_INSERT, 32'h0001_8000, 16'h5A5A);
        send_item(ACT_QUERY,  32'h0001_8000, 16'hA5A5);
        send_item(ACT_INSERT, 32'h7FFF_FFFF, 16'h0001);
        send_item(ACT_QUERY,  32'hBFFF_FFFF, 16'h0000);
        send_item(ACT_QUERY,  32'h8000_0000, 16'h0000);
        send_item(ACT_INSERT, 32'h0000_0000, 16'hFFFF);
        send_item(ACT_QUERY,  32'h0000_0001, 16'h0000);
        send_item(ACT_INSERT, 32'h0000_0001, 16'h0002);
        send_item(ACT_QUERY,  32'h0000_0001, 16'h0000);
        send_item(ACT_INSERT, 32'hFFFF_FFFE, 16'h7FFF);
        send_item(ACT_QUERY,  32'hFFFF_FFFF, 16'h0000);
        drain_results();

        // Random traffic on a partly filled table.
        send_random(320, 100, 220);
        drain_results();

        // Fill the table to capacity with fresh masses.
        while (table_model.fill < TABLE_DEPTH)
            send_item(ACT_INSERT, $urandom, IN_ID_W'($urandom));

        // Full table: new masses are refused, known masses still replace.
        send_random(330, 0, 150);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (table_model.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
